>>> hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/far_pkg.sv
package far_pkg;

    localparam int AXES     = 4;
    localparam int AXIS_W   = 2;
    localparam int TARGET_W = 18;
    localparam int OUT_W    = 15;
    localparam int STEP_W   = 15;

    localparam int ANGLE_FRAC_BITS = 12;

    localparam logic [STEP_W-1:0] STEP_RESET = 15'd41;

    // pi scaled by 2^32, rounded to nearest at the fraction width at elaboration
    localparam longint PI_SCALED32 = 64'sd13493037705;

    typedef logic signed [TARGET_W-1:0] t_target;
    typedef logic signed [OUT_W-1:0]    t_out_angle;
    typedef logic [STEP_W-1:0]          t_step;

endpackage

>>> hw/rtl/far_cfg_if.sv
interface far_cfg_if import far_pkg::*; ();
    logic  valid;
    logic  ready;
    t_step step_size;

    modport source (output valid, output step_size, input ready);
    modport sink   (input valid, input step_size, output ready);
endinterface

>>> hw/rtl/far_in_if.sv
interface far_in_if import far_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    mode;
    t_target target_left_front;
    t_target target_right_front;
    t_target target_left_back;
    t_target target_right_back;

    modport source (
        output valid, output mode,
        output target_left_front, output target_right_front,
        output target_left_back, output target_right_back,
        input ready
    );
    modport sink (
        input valid, input mode,
        input target_left_front, input target_right_front,
        input target_left_back, input target_right_back,
        output ready
    );
endinterface

>>> hw/rtl/far_out_if.sv
interface far_out_if import far_pkg::*; ();
    logic       valid;
    logic       ready;
    t_out_angle angle_left_front;
    t_out_angle angle_right_front;
    t_out_angle angle_left_back;
    t_out_angle angle_right_back;
    logic       move_done;

    modport source (
        output valid,
        output angle_left_front, output angle_right_front,
        output angle_left_back, output angle_right_back,
        output move_done,
        input ready
    );
    modport sink (
        input valid,
        input angle_left_front, input angle_right_front,
        input angle_left_back, input angle_right_back,
        input move_done,
        output ready
    );
endinterface

>>> hw/rtl/far_div.sv
module far_div #(
    parameter int W = 19
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient,
    output logic [W-1:0] o_remainder
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [W:0]    n_shift;
    logic [W:0]    n_trial;

    // one quotient bit per cycle, restoring
    assign n_shift = {r_rem, r_quo[W-1]};
    assign n_trial = n_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_cnt  <= CW'(W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!n_trial[W]) begin
                    r_rem <= n_trial[W-1:0];
                    r_quo <= {r_quo[W-2:0], 1'b1};
                end else begin
                    r_rem <= n_shift[W-1:0];
                    r_quo <= {r_quo[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

>>> hw/rtl/far_wrap.sv
module far_wrap #(
    parameter int VW   = 19,
    parameter int HW   = 15,
    parameter int PI_Q = 12868
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [VW-1:0] i_value,
    output logic                 o_done,
    output logic signed [HW-1:0] o_angle
);

    localparam logic signed [VW-1:0] L_PI   = VW'(PI_Q);
    localparam logic signed [VW-1:0] L_NPI  = VW'(-PI_Q);
    localparam logic signed [VW-1:0] L_TURN = VW'(2 * PI_Q);

    logic signed [VW-1:0] r_val;
    logic                 r_busy;
    logic                 r_done;

    logic                 n_above;
    logic                 n_below;
    logic signed [VW-1:0] n_val;

    // one whole turn per cycle through a single adder
    assign n_above = r_val > L_PI;
    assign n_below = r_val < L_NPI;
    assign n_val   = r_val + (n_above ? -L_TURN : L_TURN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_val  <= i_value;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (n_above || n_below) begin
                    r_val <= n_val;
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = HW'(r_val);

endmodule

>>> hw/rtl/four_axis_angle_ramp.sv
// channel  dir  handshake    word
// i_cfg    in   valid/ready  step_size, 15 b unsigned, always ready
// i_in     in   valid/ready  mode, four targets, 18 b signed
// o_out    out  valid/ready  four angles, 15 b signed, move_done
//
// Move word: divider width NW = max(18, F + 3) + 1; the shared restoring
// divider (one bit a cycle) runs for maxd / step, then for each axis.
// Tick word: each axis in turn loses whole turns in the shared wrap adder;
// idle ticks produce no result. Result sits in an output
// register; the next word is accepted once that register is loaded.
// Reset is synchronous, active low: held angles zero, step_size 41, idle.
`include "assert_macros.svh"

module four_axis_angle_ramp import far_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    far_cfg_if.sink   i_cfg,
    far_in_if.sink    i_in,
    far_out_if.source o_out
);

    localparam int PI_Q = int'((PI_SCALED32 + (64'sd1 <<< (31 - ANGLE_FRAC_BITS)))
                               >>> (32 - ANGLE_FRAC_BITS));
    localparam int HW = ANGLE_FRAC_BITS + 3;
    localparam int MW = (HW > TARGET_W) ? HW : TARGET_W;
    localparam int DW = MW + 1;
    localparam int NW = MW + 1;

    localparam logic signed [HW-1:0] L_PI  = HW'(PI_Q);
    localparam logic signed [HW-1:0] L_NPI = HW'(-PI_Q);

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_NGO, S_NWAIT, S_QGO, S_QWAIT, S_WGO, S_WWAIT, S_OUT
    } t_state;

    t_state                 r_state;
    logic [AXIS_W-1:0]      r_axis;
    t_step                  r_step;
    logic signed [HW-1:0]   r_held  [AXES];
    logic signed [HW-1:0]   r_start [AXES];
    t_target                r_goal  [AXES];
    logic                   r_neg   [AXES];
    logic [MW-1:0]          r_mag   [AXES];
    logic [MW-1:0]          r_qd    [AXES];
    logic [NW-1:0]          r_rd    [AXES];
    logic [MW:0]            r_q     [AXES];
    logic [NW-1:0]          r_r     [AXES];
    logic [MW-1:0]          r_maxd;
    logic [NW-1:0]          r_index;
    logic [NW-1:0]          r_total;
    logic                   r_moving;
    logic                   r_last;
    logic                   r_out_valid;
    t_out_angle             r_out_ang [AXES];
    logic                   r_out_done;

    t_target                w_tgt [AXES];
    logic                   w_in_acc;
    logic signed [DW-1:0]   w_diff;
    logic [MW-1:0]          w_mag;
    t_step                  w_step;
    logic                   w_div_start;
    logic [NW-1:0]          w_dividend;
    logic [NW-1:0]          w_divisor;
    logic                   w_div_done;
    logic [NW-1:0]          w_quo;
    logic [NW-1:0]          w_rem;
    logic signed [DW:0]     w_qs;
    logic signed [DW:0]     w_sum;
    logic signed [DW-1:0]   w_value;
    logic [NW:0]            n_rsum;
    logic                   w_wrap_done;
    logic signed [HW-1:0]   w_wrap_angle;
    logic                   w_held_ok;

    assign w_tgt[0] = i_in.target_left_front;
    assign w_tgt[1] = i_in.target_right_front;
    assign w_tgt[2] = i_in.target_left_back;
    assign w_tgt[3] = i_in.target_right_back;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in.valid && (r_state == S_IDLE);

    assign w_diff = DW'(r_goal[r_axis]) - DW'(r_start[r_axis]);
    assign w_mag  = MW'(w_diff[DW-1] ? -w_diff : w_diff);
    assign w_step = (r_step == '0) ? STEP_W'(1) : r_step;

    // shared divider: first maxd / step, then each |diff| / N
    assign w_div_start = (r_state == S_NGO) || (r_state == S_QGO);
    assign w_dividend  = (r_state == S_NGO) ? NW'(r_maxd) : NW'(r_mag[r_axis]);
    assign w_divisor   = (r_state == S_NGO) ? NW'(w_step) : r_total;

    far_div #(.W(NW)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // point i of an axis: start +/- floor(|diff| * i / N), kept as q, r
    assign w_qs    = r_neg[r_axis] ? -$signed({1'b0, r_q[r_axis]})
                                   :  $signed({1'b0, r_q[r_axis]});
    assign w_sum   = (DW + 1)'(r_start[r_axis]) + w_qs;
    assign w_value = r_last ? DW'(r_goal[r_axis]) : DW'(w_sum);
    assign n_rsum  = (NW + 1)'(r_r[r_axis]) + (NW + 1)'(r_rd[r_axis]);

    far_wrap #(.VW(DW), .HW(HW), .PI_Q(PI_Q)) u_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_WGO),
        .i_value (w_value),
        .o_done  (w_wrap_done),
        .o_angle (w_wrap_angle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= '0;
            r_step      <= STEP_RESET;
            r_moving    <= 1'b0;
            r_last      <= 1'b0;
            r_index     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < AXES; k++) begin
                r_held[k] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                r_step <= i_cfg.step_size;
            end
            if (r_out_valid && o_out.ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_axis <= '0;
                    if (w_in_acc) begin
                        if (i_in.mode) begin
                            for (int k = 0; k < AXES; k++) begin
                                r_goal[k]  <= w_tgt[k];
                                r_start[k] <= r_held[k];
                            end
                            r_moving <= 1'b0;
                            r_index  <= '0;
                            r_maxd   <= '0;
                            r_state  <= S_DIFF;
                        end else if (r_moving) begin
                            r_last <= (r_index > r_total);
                            if (r_index <= r_total) begin
                                r_index <= r_index + NW'(1);
                            end else begin
                                r_moving <= 1'b0;
                            end
                            r_state <= S_WGO;
                        end
                    end
                end
                S_DIFF: begin
                    r_neg[r_axis] <= w_diff[DW-1];
                    r_mag[r_axis] <= w_mag;
                    if (w_mag > r_maxd) begin
                        r_maxd <= w_mag;
                    end
                    r_axis <= r_axis + AXIS_W'(1);
                    if (r_axis == AXIS_W'(AXES - 1)) begin
                        r_state <= S_NGO;
                    end
                end
                S_NGO: begin
                    r_state <= S_NWAIT;
                end
                S_NWAIT: begin
                    if (w_div_done) begin
                        r_total <= w_quo + NW'(1);
                        r_axis  <= '0;
                        r_state <= S_QGO;
                    end
                end
                S_QGO: begin
                    r_state <= S_QWAIT;
                end
                S_QWAIT: begin
                    if (w_div_done) begin
                        r_qd[r_axis] <= MW'(w_quo);
                        r_rd[r_axis] <= w_rem;
                        r_q[r_axis]  <= '0;
                        r_r[r_axis]  <= '0;
                        r_axis       <= r_axis + AXIS_W'(1);
                        if (r_axis == AXIS_W'(AXES - 1)) begin
                            r_moving <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_state <= S_QGO;
                        end
                    end
                end
                S_WGO: begin
                    // advance this axis to the next point
                    if (!r_last) begin
                        if (n_rsum >= (NW + 1)'(r_total)) begin
                            r_r[r_axis] <= NW'(n_rsum - (NW + 1)'(r_total));
                            r_q[r_axis] <= r_q[r_axis] + (MW + 1)'(r_qd[r_axis])
                                         + (MW + 1)'(1);
                        end else begin
                            r_r[r_axis] <= NW'(n_rsum);
                            r_q[r_axis] <= r_q[r_axis] + (MW + 1)'(r_qd[r_axis]);
                        end
                    end
                    r_state <= S_WWAIT;
                end
                S_WWAIT: begin
                    if (w_wrap_done) begin
                        r_held[r_axis] <= w_wrap_angle;
                        r_axis         <= r_axis + AXIS_W'(1);
                        if (r_axis == AXIS_W'(AXES - 1)) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_WGO;
                        end
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        for (int k = 0; k < AXES; k++) begin
                            r_out_ang[k] <= OUT_W'(r_held[k]);
                        end
                        r_out_done  <= r_last;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.angle_left_front  = r_out_ang[0];
    assign o_out.angle_right_front = r_out_ang[1];
    assign o_out.angle_left_back   = r_out_ang[2];
    assign o_out.angle_right_back  = r_out_ang[3];
    assign o_out.move_done         = r_out_done;

    always_comb begin
        w_held_ok = 1'b1;
        for (int k = 0; k < AXES; k++) begin
            if (r_held[k] > L_PI || r_held[k] < L_NPI) begin
                w_held_ok = 1'b0;
            end
        end
    end

    `ASSERT_IMP(a_div_done_wait, i_clk, i_rst_n, w_div_done, (r_state == S_NWAIT) || (r_state == S_QWAIT), "divider finished outside a wait state")
    `ASSERT_IMP(a_index_bound, i_clk, i_rst_n, r_moving, (NW + 1)'(r_index) <= (NW + 1)'(r_total) + (NW + 1)'(1), "point index ran past the last point")
    `ASSERT_IMP(a_held_range, i_clk, i_rst_n, 1'b1, w_held_ok, "held angle outside plus minus pi")
    `ASSERT_NEXT(a_tick_busy, i_clk, i_rst_n, w_in_acc && !i_in.mode && r_moving, !i_in.ready, "ready during a running tick")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import far_pkg::*;

    localparam int     FRAC_BITS = ANGLE_FRAC_BITS;
    localparam longint PI_Q      = (PI_SCALED32 + (64'sd1 << (31 - FRAC_BITS)))
                                   >>> (32 - FRAC_BITS);
    localparam longint TURN_Q    = 2 * PI_Q;
    localparam longint TGT_MAX   = (64'sd1 <<< (TARGET_W - 1)) - 1;
    localparam longint TGT_MIN   = -(64'sd1 <<< (TARGET_W - 1));
    localparam int     SETTLE    = 150;
    localparam int     LIMIT     = 1000000;
    localparam int     PHASE_WORDS = 240;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic    mode;
        t_target tgt[AXES];
    } in_word_t;

    typedef struct {
        t_out_angle ang[AXES];
        logic       done;
    } out_word_t;

    typedef struct {
        longint held[AXES];
        longint start[AXES];
        longint goal[AXES];
        longint point_idx;
        longint point_cnt;
        bit     moving;
        t_step  step;
    } ramp_state_t;

    logic clk;
    logic rst_n;

    far_cfg_if cfg_if ();
    far_in_if  in_if ();
    far_out_if out_if ();

    four_axis_angle_ramp i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    ramp_state_t plan_state;
    ramp_state_t ramp_model;
    in_word_t    pending_words[$];
    out_word_t   angle_queue[$];
    in_word_t    on_bus;
    out_word_t   mon_expect;
    out_word_t   mon_actual;
    idle_mode_t  idle_mode;
    int          errors;
    int          phase_words;
    int          cycle_count;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    function automatic ramp_state_t ramp_reset();
        ramp_state_t s;
        for (int k = 0; k < AXES; k++) begin
            s.held[k]  = 0;
            s.start[k] = 0;
            s.goal[k]  = 0;
        end
        s.point_idx = 0;
        s.point_cnt = 0;
        s.moving    = 1'b0;
        s.step      = STEP_RESET;
        return s;
    endfunction

    // pull into [-pi, pi] by whole turns
    function automatic longint wrap_turns(longint a);
        if (a > PI_Q)
            a -= ((a - PI_Q + TURN_Q - 1) / TURN_Q) * TURN_Q;
        else if (a < -PI_Q)
            a += ((-PI_Q - a + TURN_Q - 1) / TURN_Q) * TURN_Q;
        return a;
    endfunction

    function automatic void ramp_advance(inout ramp_state_t s, input in_word_t w,
                                         output bit emitted, output out_word_t r);
        longint ang[AXES];
        longint d;
        longint maxd;
        longint stp;
        longint v;
        emitted = 1'b0;
        r.done  = 1'b0;
        for (int k = 0; k < AXES; k++) r.ang[k] = '0;
        if (w.mode) begin
            maxd = 0;
            stp  = (s.step == 0) ? 1 : longint'(s.step);
            for (int k = 0; k < AXES; k++) begin
                s.start[k] = s.held[k];
                s.goal[k]  = longint'(w.tgt[k]);
                d = s.goal[k] - s.start[k];
                if (d < 0) d = -d;
                if (d > maxd) maxd = d;
            end
            s.point_cnt = maxd / stp + 1;
            s.point_idx = 0;
            s.moving    = 1'b1;
            return;
        end
        if (!s.moving) return;
        if (s.point_idx <= s.point_cnt) begin
            for (int k = 0; k < AXES; k++)
                ang[k] = wrap_turns(s.start[k] +
                                    ((s.goal[k] - s.start[k]) * s.point_idx) / s.point_cnt);
            s.point_idx++;
        end else begin
            for (int k = 0; k < AXES; k++) ang[k] = wrap_turns(s.goal[k]);
            s.moving = 1'b0;
            r.done   = 1'b1;
        end
        for (int k = 0; k < AXES; k++) begin
            s.held[k] = ang[k];
            v = ang[k];
            r.ang[k] = v[OUT_W-1:0];
        end
        emitted = 1'b1;
    endfunction

    function automatic int send_hold_pct(idle_mode_t m);
        return (m == IDLE_SEND) ? 82 : (m == IDLE_BOTH) ? 12 : 0;
    endfunction

    function automatic int recv_stall_pct(idle_mode_t m);
        return (m == IDLE_RECV) ? 82 : (m == IDLE_BOTH) ? 12 : 0;
    endfunction

    // input driver: hold the word until taken, predict on acceptance
    always @(posedge clk) begin
        bit        got;
        out_word_t res;
        if (!rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                ramp_advance(ramp_model, on_bus, got, res);
                if (got) angle_queue.push_back(res);
            end
            if (!in_if.valid || in_if.ready) begin
                if (pending_words.size() > 0 &&
                    $urandom_range(0, 99) >= send_hold_pct(idle_mode)) begin
                    on_bus = pending_words.pop_front();
                    in_if.valid              <= 1'b1;
                    in_if.mode               <= on_bus.mode;
                    in_if.target_left_front  <= on_bus.tgt[0];
                    in_if.target_right_front <= on_bus.tgt[1];
                    in_if.target_left_back   <= on_bus.tgt[2];
                    in_if.target_right_back  <= on_bus.tgt[3];
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                mon_actual.ang[0] = out_if.angle_left_front;
                mon_actual.ang[1] = out_if.angle_right_front;
                mon_actual.ang[2] = out_if.angle_left_back;
                mon_actual.ang[3] = out_if.angle_right_back;
                mon_actual.done   = out_if.move_done;
                if (angle_queue.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual done=%0b",
                             $time, mon_actual.done);
                end else begin
                    mon_expect = angle_queue.pop_front();
                    for (int k = 0; k < AXES; k++) begin
                        if (mon_actual.ang[k] !== mon_expect.ang[k]) begin
                            errors++;
                            $display("%0t: axis %0d angle expected %0d actual %0d",
                                     $time, k, mon_expect.ang[k], mon_actual.ang[k]);
                        end
                    end
                    if (mon_actual.done !== mon_expect.done) begin
                        errors++;
                        $display("%0t: move_done expected %0b actual %0b",
                                 $time, mon_expect.done, mon_actual.done);
                    end
                end
            end
            out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct(idle_mode));
        end
    end

    function automatic in_word_t rand_word(logic mode);
        in_word_t w;
        w.mode = mode;
        for (int k = 0; k < AXES; k++) w.tgt[k] = t_target'($urandom);
        return w;
    endfunction

    task automatic queue_word(input in_word_t w);
        bit        got;
        out_word_t res;
        ramp_advance(plan_state, w, got, res);
        if (w.mode || got) phase_words++;
        pending_words.push_back(w);
    endtask

    task automatic queue_ticks(input longint n);
        for (longint i = 0; i < n; i++) queue_word(rand_word(1'b0));
    endtask

    // n_ticks below zero: tick through to the done word
    task automatic queue_move_to(input longint a, input longint b, input longint c,
                                 input longint d, input longint n_ticks);
        in_word_t w;
        w = rand_word(1'b1);
        w.tgt[0] = t_target'(a);
        w.tgt[1] = t_target'(b);
        w.tgt[2] = t_target'(c);
        w.tgt[3] = t_target'(d);
        queue_word(w);
        queue_ticks(n_ticks < 0 ? plan_state.point_cnt + 2 : n_ticks);
    endtask

    task automatic queue_random_move();
        in_word_t w;
        longint   stp;
        longint   bound;
        longint   v;
        longint   n;
        int       sel;
        sel = $urandom_range(0, 9);
        stp = (plan_state.step == 0) ? 1 : longint'(plan_state.step);
        w = rand_word(1'b1);
        // most moves stay within a dozen steps of the held angles
        if (sel >= 2) begin
            bound = stp * $urandom_range(0, 12);
            if (bound > TGT_MAX) bound = TGT_MAX;
            for (int k = 0; k < AXES; k++) begin
                v = plan_state.held[k] + longint'($urandom_range(0, 32'(2 * bound))) - bound;
                if (v > TGT_MAX) v = TGT_MAX;
                if (v < TGT_MIN) v = TGT_MIN;
                w.tgt[k] = t_target'(v);
            end
        end
        queue_word(w);
        n = plan_state.point_cnt;
        if (n <= 40 && $urandom_range(0, 4) != 0)
            queue_ticks(n + 2 + $urandom_range(0, 2));
        else
            queue_ticks($urandom_range(0, (n < 30) ? 32'(n) : 32'(30)));
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || in_if.valid || angle_queue.size() > 0)
            @(posedge clk);
        // a trailing move word yields no result but keeps the divider busy
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_step(input t_step v);
        wait_drained();
        @(posedge clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.step_size <= v;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        plan_state.step = v;
        ramp_model.step = v;
    endtask

    initial begin
        t_step steps[8];
        cfg_if.valid              = 1'b0;
        cfg_if.step_size          = '0;
        in_if.valid               = 1'b0;
        in_if.mode                = 1'b0;
        in_if.target_left_front   = '0;
        in_if.target_right_front  = '0;
        in_if.target_left_back    = '0;
        in_if.target_right_back   = '0;
        out_if.ready              = 1'b0;
        errors      = 0;
        phase_words = 0;
        idle_mode   = IDLE_NONE;
        plan_state  = ramp_reset();
        ramp_model  = ramp_reset();
        rst_n       = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset step size: idle ticks, a short move, a move cut short by another
        queue_ticks(1);
        queue_move_to(100, -100, 41, 0, -1);
        queue_ticks(1);
        queue_move_to(200, -200, 300, -300, 2);
        queue_move_to(0, 0, 0, 0, -1);

        // largest step: target extremes and the pi boundaries
        write_step(t_step'(32767));
        queue_move_to(TGT_MAX, TGT_MAX, TGT_MAX, TGT_MAX, -1);
        queue_move_to(TGT_MIN, PI_Q, -PI_Q - 1, PI_Q + 1, -1);

        steps[0] = t_step'(25736);
        steps[1] = t_step'(1);
        steps[2] = t_step'(0);
        steps[3] = STEP_RESET;
        steps[4] = t_step'($urandom_range(1, 25736));
        steps[5] = t_step'(32767);
        steps[6] = t_step'($urandom_range(1, 200));
        steps[7] = t_step'($urandom_range(1, 25736));
        for (int p = 0; p < 8; p++) begin
            write_step(steps[p]);
            idle_mode   = idle_mode_t'(p % 4);
            phase_words = 0;
            while (phase_words < PHASE_WORDS) queue_random_move();
        end

        wait_drained();
        if (errors == 0 && angle_queue.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            if (angle_queue.size() > 0)
                $display("%0t: %0d expected results never arrived",
                         $time, angle_queue.size());
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin
        while (cycle_count < LIMIT) @(posedge clk);
        $display("%0t: timeout", $time);
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
